FILE: hw/rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types for the trial division prime test
// Sequencer states and the control word of the serial remainder unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUND,
        ST_DIVIDE,
        ST_CHECK,
        ST_FINISH
    } tdpt_state_t;

    typedef struct packed {
        logic load;   // clear the partial remainder
        logic step;   // shift in one dividend bit and reduce
    } tdpt_rem_ctrl_t;

endpackage

FILE: hw/rtl/tdpt_rem_unit.sv
// ----------------------------------------------------------------------------
// tdpt_rem_unit: bit-serial restoring remainder
// One dividend bit per step, MSB first; one compare-subtract per cycle while step is high.
// ----------------------------------------------------------------------------
module tdpt_rem_unit #(
    parameter int DIV_W = 17
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tdpt_pkg::tdpt_rem_ctrl_t ctrl,
    input  logic                   dividend_bit,
    input  logic [DIV_W-1:0]       divisor,
    output logic [DIV_W-1:0]       remainder
);
    import tdpt_pkg::*;

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    assign trial = {rem_reg, dividend_bit};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        rem_next = rem_reg;
        if (ctrl.load)
        begin
            rem_next = '0;
        end
        else if (ctrl.step)
        begin
            // trial < 2*divisor, so the reduced value fits DIV_W bits
            if (trial >= {1'b0, divisor})
                rem_next = diff[DIV_W-1:0];
            else
                rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    assign remainder = rem_reg;

endmodule

FILE: hw/rtl/trial_division_prime_test_unit.sv
// Values <= 1 or negative go straight to the result; otherwise each trial
// divisor takes a bound state, DATA_WIDTH steps of the serial remainder
// unit and a check state.
// Throughput: one item at a time; in_stall is high from accept until the
// result is loaded into the output register.
// Reset: rst_n asynchronous active low returns to idle with no result pending.
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit: trial division primality test
// Tries divisors d = 2, 3, ... while d*d <= n using a serial remainder unit;
// d*d is tracked incrementally.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] number,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         is_prime
);
    import tdpt_pkg::*;

    localparam int DIV_W = DATA_WIDTH / 2 + 1;
    localparam int SQ_W  = DATA_WIDTH + 1;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    tdpt_state_t     state_reg, state_next;
    tdpt_rem_ctrl_t  rem_ctrl;

    logic [DATA_WIDTH-1:0] n_reg, n_next;
    logic [DATA_WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  result_reg, result_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  is_prime_reg, is_prime_next;
    logic [DIV_W-1:0]      remainder;

    logic in_xfer;
    logic trivial;
    logic over_bound;
    logic last_step;
    logic out_free;

    assign in_xfer    = in_valid && !in_stall;
    assign trivial    = number[DATA_WIDTH-1] || (number <= $signed(DATA_WIDTH'(1)));
    assign over_bound = sq_reg > {1'b0, n_reg};
    assign last_step  = cnt_reg == CNT_W'(DATA_WIDTH - 1);
    assign out_free   = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = trivial ? ST_FINISH : ST_BOUND;
            end
            ST_BOUND:
            begin
                state_next = over_bound ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (last_step)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = (remainder == '0) ? ST_FINISH : ST_BOUND;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        n_next         = n_reg;
        shift_next     = shift_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        cnt_next       = cnt_reg;
        result_next    = result_reg;
        rem_ctrl       = '0;
        out_valid_next = out_valid_reg && out_stall;
        is_prime_next  = is_prime_reg;
        in_stall       = state_reg != ST_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next      = number;
                    div_next    = DIV_W'(2);
                    sq_next     = SQ_W'(4);
                    result_next = 1'b0;
                end
            end
            ST_BOUND:
            begin
                result_next = over_bound;
                shift_next  = n_reg;
                cnt_next    = '0;
                rem_ctrl.load = 1'b1;
            end
            ST_DIVIDE:
            begin
                rem_ctrl.step = 1'b1;
                shift_next    = {shift_reg[DATA_WIDTH-2:0], 1'b0};
                cnt_next      = cnt_reg + CNT_W'(1);
            end
            ST_CHECK:
            begin
                // (d+1)^2 = d^2 + 2d + 1
                sq_next     = sq_reg + {{(SQ_W-DIV_W-1){1'b0}}, div_reg, 1'b1};
                div_next    = div_reg + DIV_W'(1);
                result_next = 1'b0;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = result_reg;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    tdpt_rem_unit #(
        .DIV_W(DIV_W)
    ) u_rem (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (rem_ctrl),
        .dividend_bit (shift_reg[DATA_WIDTH-1]),
        .divisor      (div_reg),
        .remainder    (remainder)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        shift_reg    <= shift_next;
        div_reg      <= div_next;
        sq_reg       <= sq_next;
        result_reg   <= result_next;
        is_prime_reg <= is_prime_next;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    // negative numbers go straight to a not-prime result
    a_negative_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && number[DATA_WIDTH-1] |=> state_reg == ST_FINISH && !result_reg)
        else $error("negative input not rejected at once");

    // a division always starts from a cleared counter
    a_divide_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BOUND && !over_bound |=> state_reg == ST_DIVIDE && cnt_reg == '0)
        else $error("division started with stale step count");

    // the reduced remainder stays below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> remainder < div_reg)
        else $error("remainder not below divisor");

    // the divisor is never below two during a division
    a_div_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> div_reg >= DIV_W'(2))
        else $error("trial divisor below two");

endmodule
